FILE: design/rational_arith_unit_macros.svh
// Assertion macros for the rational arithmetic unit.
// Depends on nothing; included by the top level.
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH
`ifndef SYNTH
`define RAU_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RAU_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RAU_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RAU_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: design/rau_pkg.sv
// Package for the rational arithmetic unit: payload structs, opcodes, codes.
// Depends on nothing.
`default_nettype none
package rau_pkg;
  localparam int WIDTH = 32;
  localparam int PW = 2 * WIDTH;

  typedef enum logic [2:0] {
    OP_NORM = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_MUL = 3'd3,
    OP_DIV = 3'd4, OP_ABS = 3'd5, OP_CMP = 3'd6, OP_MIX = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DZ = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;
  localparam logic [1:0] ORD_EQ = 2'd0;
  localparam logic [1:0] ORD_LT = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic signed [31:0] first_num;
    logic signed [31:0] first_den;
    logic signed [31:0] second_num;
    logic signed [31:0] second_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic [30:0] result_den;
    logic signed [31:0] integer_part;
    logic [1:0] order;
    logic [1:0] status;
  } out_item_t;

  // classified job passed from front to back
  typedef struct packed {
    op_t op;
    logic dz;
    logic neg;
    logic [WIDTH-1:0] ma;
    logic [WIDTH-1:0] mb;
    logic [WIDTH-1:0] mc;
    logic [WIDTH-1:0] md;
    logic sa;
    logic sb;
    logic sc;
    logic sd;
  } job_t;
endpackage
`default_nettype wire

FILE: design/rau_front.sv
// Front end: accepts transactions, takes magnitudes and signs, flags zero
// denominators. Depends on rau_pkg.
`default_nettype none
module rau_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  rau_pkg::in_item_t  in_data,
  output logic               job_valid,
  input  wire logic          job_ready,
  output rau_pkg::job_t      job
);
  import rau_pkg::*;

  // two-entry job queue
  job_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  job_t cj;
  logic [WIDTH-1:0] a, b, c, d;
  logic bin, push, pop;

  assign a = in_data.first_num[WIDTH-1:0];
  assign b = in_data.first_den[WIDTH-1:0];
  assign c = in_data.second_num[WIDTH-1:0];
  assign d = in_data.second_den[WIDTH-1:0];

  // classify
  always_comb begin
    cj.op = op_t'(in_data.opcode);
    bin = (cj.op == OP_ADD) || (cj.op == OP_SUB) || (cj.op == OP_MUL) || (cj.op == OP_DIV);
    cj.sa = a[WIDTH-1];
    cj.sb = b[WIDTH-1];
    cj.sc = c[WIDTH-1];
    cj.sd = d[WIDTH-1];
    cj.ma = cj.sa ? -a : a;
    cj.mb = cj.sb ? -b : b;
    cj.mc = cj.sc ? -c : c;
    cj.md = cj.sd ? -d : d;
    cj.dz = (b == '0) || ((bin || cj.op == OP_CMP) && d == '0) ||
            (cj.op == OP_DIV && c == '0);
    cj.neg = 1'b0;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign pop = job_valid && job_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cj;
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end
endmodule
`default_nettype wire

FILE: design/rau_divider.sv
// Shared restoring divider, one quotient bit a cycle over PW-bit operands.
// Depends on rau_pkg.
`default_nettype none
module rau_divider (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [rau_pkg::PW-1:0]   dividend,
  input  wire logic [rau_pkg::PW-1:0]   divisor,
  output logic                          done,
  output logic [rau_pkg::PW-1:0]        quot,
  output logic [rau_pkg::PW-1:0]        rem
);
  import rau_pkg::*;

  localparam int CW = $clog2(PW + 1);
  logic [PW-1:0] q_r, r_r, dv_r;
  logic [CW-1:0] cnt_r;
  logic busy_r;
  logic [PW:0] tr;

  assign tr = {r_r, q_r[PW-1]} - {1'b0, dv_r};
  assign quot = q_r;
  assign rem = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q_r <= dividend;
        r_r <= '0;
        dv_r <= divisor;
        cnt_r <= CW'(PW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // shift in one bit, subtract if it fits
        if (!tr[PW]) begin
          r_r <= tr[PW-1:0];
          q_r <= {q_r[PW-2:0], 1'b1};
        end else begin
          r_r <= {r_r[PW-2:0], q_r[PW-1]};
          q_r <= {q_r[PW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/rau_back.sv
// Back end: products, compare, Euclidean GCD, reduction, saturation, output register.
// Depends on rau_pkg and rau_divider.
`default_nettype none
module rau_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  output logic                job_ready,
  input  rau_pkg::job_t       job,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rau_pkg::out_item_t  out_data
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MIX, S_MIXW, S_GCD, S_GCDW,
    S_RN, S_RNW, S_RD, S_RDW, S_FIN, S_OUT
  } state_t;

  state_t st_r;
  job_t j_r;
  logic [PW-1:0] p1_r, p2_r, pd_r, nm_r, dm_r, x_r, y_r, q_r;
  logic neg_r;
  logic [1:0] ord_r;
  logic signed [WIDTH-1:0] ip_r;
  logic dstart;
  logic [PW-1:0] dvd, dvs, dq, drm;
  logic ddone;
  logic [WIDTH-1:0] m1a, m1b, m2a, m2b;
  logic [PW-1:0] mp1, mp2;
  logic s1, s2, sx;
  logic [PW-1:0] pmax, nlim;
  logic [PW-1:0] fn, fd;
  logic fneg;
  logic [1:0] fst;
  logic signed [WIDTH-1:0] onum;

  rau_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(dvd), .divisor(dvs),
    .done(ddone), .quot(dq), .rem(drm)
  );

  assign job_ready = (st_r == S_IDLE);
  assign pmax = PW'((64'd1 << (WIDTH - 1)) - 64'd1);

  // product operand selection per opcode
  always_comb begin
    m1a = j_r.ma; m1b = j_r.md; m2a = j_r.mb; m2b = j_r.mc;
    if (j_r.op == OP_MUL) begin
      m1b = j_r.mc; m2b = j_r.md;
    end
  end
  assign mp1 = PW'(m1a) * PW'(m1b);
  assign mp2 = PW'(m2a) * PW'(m2b);

  // signed combination of cross products for add and subtract
  assign s1 = j_r.sa ^ j_r.sd;
  assign s2 = (j_r.sb ^ j_r.sc) ^ (j_r.op == OP_SUB);
  assign sx = j_r.sb ^ j_r.sd;

  // divider start and operands
  always_comb begin
    dstart = 1'b0; dvd = x_r; dvs = y_r;
    unique case (st_r)
      S_MIX: begin dstart = 1'b1; dvd = PW'(j_r.ma); dvs = PW'(j_r.mb); end
      S_GCD: dstart = (y_r != '0);
      S_RN:  begin dstart = 1'b1; dvd = nm_r; dvs = x_r; end
      S_RD:  begin dstart = 1'b1; dvd = dm_r; dvs = x_r; end
      default: ;
    endcase
  end

  // saturation of the reduced fraction
  always_comb begin
    fn = nm_r; fd = dm_r; fneg = neg_r; fst = ST_OK;
    if (fn == '0) begin fneg = 1'b0; fd = PW'(1); end
    nlim = fneg ? pmax + PW'(1) : pmax;
    if (fn > nlim || fd > pmax) begin
      fst = ST_OVF;
      if (fn >= fd) fn = nlim;
      else begin fn = '0; fneg = 1'b0; end
      fd = PW'(1);
    end
    onum = fneg ? -fn[WIDTH-1:0] : fn[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (job_valid) begin
          j_r <= job;
          ord_r <= ORD_EQ;
          ip_r <= '0;
          if (job.dz) begin
            out_data <= '{result_num: '0, result_den: '0, integer_part: '0,
                          order: ORD_EQ, status: ST_DZ};
            out_valid <= 1'b1;
            st_r <= S_OUT;
          end else if (job.op == OP_NORM || job.op == OP_ABS) begin
            nm_r <= PW'(job.ma);
            dm_r <= PW'(job.mb);
            x_r <= PW'(job.ma);
            y_r <= PW'(job.mb);
            neg_r <= (job.op == OP_NORM) && (job.sa ^ job.sb);
            st_r <= S_GCD;
          end else if (job.op == OP_MIX) st_r <= S_MIX;
          else st_r <= S_MUL1;
        end
        // register products
        S_MUL1: begin
          p1_r <= mp1;
          p2_r <= mp2;
          pd_r <= PW'(j_r.mb) * PW'(j_r.md);
          st_r <= S_MUL2;
        end
        S_MUL2: begin
          st_r <= S_GCD;
          unique case (j_r.op)
            OP_ADD, OP_SUB: begin
              if (s1 == s2) begin nm_r <= p1_r + p2_r; neg_r <= s1 ^ sx; end
              else if (p1_r >= p2_r) begin nm_r <= p1_r - p2_r; neg_r <= s1 ^ sx; end
              else begin nm_r <= p2_r - p1_r; neg_r <= s2 ^ sx; end
              dm_r <= pd_r;
              x_r <= (s1 == s2) ? p1_r + p2_r : (p1_r >= p2_r ? p1_r - p2_r : p2_r - p1_r);
              y_r <= pd_r;
            end
            OP_MUL: begin
              nm_r <= p1_r; dm_r <= p2_r; x_r <= p1_r; y_r <= p2_r;
              neg_r <= (j_r.sa ^ j_r.sc) ^ (j_r.sb ^ j_r.sd);
            end
            OP_DIV: begin
              nm_r <= p1_r; dm_r <= p2_r; x_r <= p1_r; y_r <= p2_r;
              neg_r <= (j_r.sa ^ j_r.sd) ^ (j_r.sb ^ j_r.sc);
            end
            default: begin
              // compare: signed cross products
              logic signed [PW:0] l, r;
              l = (j_r.sa ^ j_r.sb) ? -$signed({1'b0, p1_r}) : $signed({1'b0, p1_r});
              r = (j_r.sc ^ j_r.sd) ? -$signed({1'b0, p2_r}) : $signed({1'b0, p2_r});
              if (p1_r == '0) l = '0;
              if (p2_r == '0) r = '0;
              ord_r <= (l == r) ? ORD_EQ : ((l < r) ? ORD_LT : ORD_GT);
              st_r <= S_FIN;
            end
          endcase
        end
        S_MIX: st_r <= S_MIXW;
        S_MIXW: if (ddone) begin
          // trunc quotient keeps sign of a xor b; remainder sign of a
          if (!(j_r.sa ^ j_r.sb) && dq > pmax) ip_r <= pmax[WIDTH-1:0];
          else ip_r <= (j_r.sa ^ j_r.sb) ? -dq[WIDTH-1:0] : dq[WIDTH-1:0];
          q_r <= dq;
          nm_r <= drm; dm_r <= PW'(j_r.mb);
          x_r <= drm; y_r <= PW'(j_r.mb);
          neg_r <= (j_r.sa && drm != '0) ^ j_r.sb;
          st_r <= S_GCD;
        end
        // Euclid: x, y <- y, x mod y
        S_GCD: if (y_r == '0) st_r <= S_RN; else st_r <= S_GCDW;
        S_GCDW: if (ddone) begin
          x_r <= y_r; y_r <= drm; st_r <= S_GCD;
        end
        S_RN: st_r <= S_RNW;
        S_RNW: if (ddone) begin nm_r <= dq; st_r <= S_RD; end
        S_RD: st_r <= S_RDW;
        S_RDW: if (ddone) begin dm_r <= dq; st_r <= S_FIN; end
        S_FIN: begin
          out_valid <= 1'b1;
          st_r <= S_OUT;
          if (j_r.op == OP_CMP) begin
            out_data <= '{result_num: '0, result_den: '0, integer_part: '0,
                          order: ord_r, status: ST_OK};
          end else begin
            out_data.result_num <= 32'(onum);
            out_data.result_den <= 31'(fd);
            out_data.integer_part <= 32'(ip_r);
            out_data.order <= ORD_EQ;
            out_data.status <= (j_r.op == OP_MIX && !(j_r.sa ^ j_r.sb) && q_r > pmax)
                               ? ST_OVF : fst;
          end
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/rational_arith_unit.sv
// Top level of the rational arithmetic unit: front, job queue, back end.
// Depends on rau_pkg, rau_front, rau_back and the assertion macro header.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | in_data  (in_item_t)
//   out_    | output    | out_valid / out_ready| out_data (out_item_t)
//
// One transaction at a time in the back end; each Euclid step runs one
// bit-serial divide on the shared divider, and the two final reduction
// divides run one each, so the time a fraction result takes depends on
// operand values. Compare passes only the product states, and zero-denominator
// items go straight to the output register, each plus any wait on out_ready.
// The front queue holds two items so input can be taken while the back works.
// Reset (synchronous, rst_n low) empties the queue and idles the back end.
`default_nettype none
`include "rational_arith_unit_macros.svh"
module rational_arith_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  rau_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rau_pkg::out_item_t out_data
);
  import rau_pkg::*;

  logic job_valid, job_ready;
  job_t job;

  rau_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  rau_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
    .job(job), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // checks
  `RAU_ASSERT_IMP(a_den_pos, clk, rst_n, out_valid && out_data.status == ST_OK && out_data.order == ORD_EQ && out_data.result_num != '0, out_data.result_den != '0)
  `RAU_ASSERT_IMP(a_dz_clear, clk, rst_n, out_valid && out_data.status == ST_DZ, out_data.result_num == '0 && out_data.result_den == '0)
  `RAU_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for rational_arith_unit: fraction ALU results checked
// against an in-bench predictor. Depends on rau_pkg and the design sources.
`default_nettype none
module tb_top;
  import rau_pkg::*;

  localparam int IDLE_LIMIT = 400000;
  localparam int END_WAIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  bit failed = 1'b0;
  int quiet_cycles = 0;
  out_item_t expected_fracs[$];

  rational_arith_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // magnitude of a signed value, 64-bit
  function automatic logic [63:0] magnitude(input logic signed [63:0] x);
    magnitude = x < 0 ? 64'd0 - x : x;
  endfunction

  function automatic logic [63:0] euclid(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    euclid = x;
  endfunction

  // reduce a sign-magnitude fraction and saturate it into the result fields
  function automatic void reduce_frac(input bit neg, input logic [63:0] nm,
                                      input logic [63:0] dm, inout out_item_t r);
    logic [63:0] pmax;
    logic [63:0] g;
    logic signed [63:0] v;
    pmax = 64'h7FFF_FFFF;
    g = euclid(nm, dm);
    nm = nm / g;
    dm = dm / g;
    r.status = ST_OK;
    if (nm == 0) begin
      neg = 1'b0;
      dm = 1;
    end
    if (nm > (neg ? pmax + 1 : pmax) || dm > pmax) begin
      r.status = ST_OVF;
      if (nm >= dm) begin
        nm = neg ? pmax + 1 : pmax;
      end else begin
        nm = 0;
        neg = 1'b0;
      end
      dm = 1;
    end
    v = neg ? -$signed(nm) : $signed(nm);
    r.result_num = v[31:0];
    r.result_den = dm[30:0];
  endfunction

  function automatic out_item_t predict_fraction(input in_item_t it);
    out_item_t r;
    logic signed [63:0] a, b, c, d, an, bp, cn, dp, l, rr, q, rm;
    logic [63:0] ma, mb, mc, md, p1, p2, nm;
    bit sa, sb, sc, sd, s1, s2, ns, binary;
    op_t op;
    r = '0;
    op = op_t'(it.opcode);
    a = it.first_num; b = it.first_den; c = it.second_num; d = it.second_den;
    sa = a < 0; sb = b < 0; sc = c < 0; sd = d < 0;
    ma = magnitude(a); mb = magnitude(b); mc = magnitude(c); md = magnitude(d);
    binary = op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
    if (b == 0 || ((binary || op == OP_CMP) && d == 0) || (op == OP_DIV && c == 0)) begin
      r.status = ST_DZ;
      return r;
    end
    case (op)
      OP_ADD, OP_SUB: begin
        s1 = sa != sd;
        s2 = (sb != sc) != (op == OP_SUB);
        p1 = ma * md;
        p2 = mb * mc;
        if (s1 == s2) begin
          nm = p1 + p2; ns = s1;
        end else if (p1 >= p2) begin
          nm = p1 - p2; ns = s1;
        end else begin
          nm = p2 - p1; ns = s2;
        end
        reduce_frac(ns != (sb != sd), nm, mb * md, r);
      end
      OP_MUL: reduce_frac((sa != sc) != (sb != sd), ma * mc, mb * md, r);
      OP_DIV: reduce_frac((sa != sd) != (sb != sc), ma * md, mb * mc, r);
      OP_ABS: reduce_frac(1'b0, ma, mb, r);
      OP_CMP: begin
        an = sb ? -a : a; bp = sb ? -b : b;
        cn = sd ? -c : c; dp = sd ? -d : d;
        l = an * dp;
        rr = cn * bp;
        r.order = l == rr ? ORD_EQ : (l < rr ? ORD_LT : ORD_GT);
      end
      OP_MIX: begin
        q = a / b;
        rm = a % b;
        reduce_frac((rm < 0) != sb, magnitude(rm), mb, r);
        if (q > 64'sh7FFF_FFFF) begin
          q = 64'sh7FFF_FFFF;
          r.status = ST_OVF;
        end
        r.integer_part = q[31:0];
      end
      default: reduce_frac(sa != sb, ma, mb, r);
    endcase
    return r;
  endfunction

  // offer one transaction, idling beforehand at random
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_fracs.push_back(predict_fraction(it));
    @(negedge clk);
  endtask

  task automatic send_op(input op_t op, input int an, input int ad,
                         input int bn, input int bd);
    send_item({op, an, ad, bn, bd});
  endtask

  // operand mixes: small values mostly, extremes and zeros now and then
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: pick_value = $urandom;
      1: pick_value = 32'h8000_0000;
      2: pick_value = 32'h7FFF_FFFF;
      3: pick_value = $urandom_range(2) - 1;
      4, 5: pick_value = $urandom & 32'h0000_FFFF;
      default: pick_value = $signed($urandom_range(2000)) - 1000;
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.opcode = 3'($urandom_range(7));
    it.first_num = pick_value();
    it.first_den = pick_value();
    it.second_num = pick_value();
    it.second_den = pick_value();
    // keep zero denominators to a minority
    if (it.first_den == 0 && $urandom_range(3) != 0) it.first_den = 1;
    if (it.second_den == 0 && $urandom_range(3) != 0) it.second_den = -7;
    return it;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_fracs.size() != 0) @(posedge clk);
  endtask

  // every opcode, extremes, zero denominators and saturation
  task automatic test_directed();
    send_op(OP_NORM, 6, -4, 0, 1);
    send_op(OP_NORM, 0, -5, 0, 1);
    send_op(OP_NORM, 32'sh8000_0000, -1, 0, 1);
    send_op(OP_NORM, 32'sh8000_0000, 1, 0, 1);
    send_op(OP_NORM, 1, 32'sh8000_0000, 0, 1);
    send_op(OP_NORM, 5, 0, 0, 1);
    send_op(OP_ADD, 1, 2, 1, 3);
    send_op(OP_ADD, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 1);
    send_op(OP_ADD, 1, 2, 1, 0);
    send_op(OP_SUB, 1, 3, 1, 2);
    send_op(OP_SUB, 32'sh8000_0000, 1, 1, 1);
    send_op(OP_MUL, -3, 4, 8, -9);
    send_op(OP_MUL, 1, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF);
    send_op(OP_DIV, 2, 3, -4, 5);
    send_op(OP_DIV, 2, 3, 0, 5);
    send_op(OP_DIV, 32'sh8000_0000, 1, -1, 1);
    send_op(OP_ABS, -7, 14, 0, 0);
    send_op(OP_ABS, 32'sh8000_0000, 1, 0, 0);
    send_op(OP_CMP, 1, 2, 2, 4);
    send_op(OP_CMP, -1, 2, 1, -3);
    send_op(OP_CMP, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 1);
    send_op(OP_CMP, 1, 2, 1, 0);
    send_op(OP_MIX, -7, 2, 0, 0);
    send_op(OP_MIX, 32'sh8000_0000, -1, 0, 0);
    send_op(OP_MIX, 7, -3, 0, 0);
    wait_drained();
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_item(random_item());
    wait_drained();
  endtask

  // receiver holds off while the sender keeps going
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b1;
    repeat (20) send_item(random_item());
    recv_hold = 1'b0;
    wait_drained();
  endtask

  // receiver: random stalls, long hold-off counted in its own cycles
  initial begin
    int held;
    held = 0;
    forever begin
      @(negedge clk);
      if (recv_hold && held < 3000) begin
        held++;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_fracs.size() == 0) begin
        $error("unexpected result transaction %p", out_data);
        failed = 1'b1;
      end else begin
        want = expected_fracs.pop_front();
        if (out_data.result_num !== want.result_num) begin
          $error("result_num: expected %0d, got %0d", want.result_num, out_data.result_num);
          failed = 1'b1;
        end
        if (out_data.result_den !== want.result_den) begin
          $error("result_den: expected %0d, got %0d", want.result_den, out_data.result_den);
          failed = 1'b1;
        end
        if (out_data.integer_part !== want.integer_part) begin
          $error("integer_part: expected %0d, got %0d", want.integer_part,
                 out_data.integer_part);
          failed = 1'b1;
        end
        if (out_data.order !== want.order) begin
          $error("order: expected %0d, got %0d", want.order, out_data.order);
          failed = 1'b1;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(300, 14, 70);
    test_random(300, 70, 14);
    test_backpressure();
    test_random(280, 0, 0);
    repeat (END_WAIT) @(posedge clk);
    if (!failed && expected_fracs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+design
design/rau_pkg.sv
design/rau_front.sv
design/rau_divider.sv
design/rau_back.sv
design/rational_arith_unit.sv
tb/tb_top.sv
